FILE: hw/rtl/cordic_sc_pkg.sv
// ----------------------------------------------------------------------------
// cordic sine/cosine package
// shared types, constants and arctangent table for the rotation chain
// ----------------------------------------------------------------------------
package cordic_sc_pkg;

	localparam int STAGES    = 16;
	localparam int DW        = 16;
	localparam int AW        = 18;
	localparam int RW        = AW + 1;
	localparam int SHW       = 4;

	localparam logic signed [RW-1:0] PI_Q      = RW'(51471);
	localparam logic signed [RW-1:0] TWO_PI_Q  = RW'(102943);
	localparam logic signed [RW-1:0] HALF_PI_Q = RW'(25735);
	localparam logic signed [DW-1:0] INV_GAIN_Q = DW'(9949);

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} vec_t;

	function automatic logic signed [DW-1:0] atan_lut(input logic [SHW-1:0] k);
		logic signed [DW-1:0] a;
		case (k)
			4'd0:    a = 16'sh3243;
			4'd1:    a = 16'sh1DAC;
			4'd2:    a = 16'sh0FAD;
			4'd3:    a = 16'sh07F5;
			4'd4:    a = 16'sh03FE;
			4'd5:    a = 16'sh01FF;
			4'd6:    a = 16'sh00FF;
			4'd7:    a = 16'sh007F;
			4'd8:    a = 16'sh003F;
			4'd9:    a = 16'sh001F;
			4'd10:   a = 16'sh000F;
			4'd11:   a = 16'sh0007;
			4'd12:   a = 16'sh0003;
			4'd13:   a = 16'sh0001;
			default: a = 16'sh0000;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/cordic_sc_prep.sv
// ----------------------------------------------------------------------------
// cordic angle preparation
// wraps the angle into [-pi, pi], folds it into [-pi/2, pi/2], sets start vector
// ----------------------------------------------------------------------------
module cordic_sc_prep (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [cordic_sc_pkg::AW-1:0]   angle,
	output logic                                  out_valid,
	output cordic_sc_pkg::vec_t                   out_vec
);
	import cordic_sc_pkg::*;

	logic signed [RW-1:0] r_ext;
	logic signed [RW-1:0] r_wrap;
	logic signed [RW-1:0] r_fold;
	logic                 neg;
	vec_t                 vec_s1;
	logic                 valid_s1;

	always_comb begin
		r_ext = RW'(angle);
		if (r_ext > PI_Q) begin
			r_wrap = r_ext - TWO_PI_Q;
		end else if (r_ext < -PI_Q) begin
			r_wrap = r_ext + TWO_PI_Q;
		end else begin
			r_wrap = r_ext;
		end
		// fold outer half-planes by pi and flip the start vector
		if (r_wrap > HALF_PI_Q) begin
			r_fold = r_wrap - PI_Q;
			neg    = 1'b1;
		end else if (r_wrap < -HALF_PI_Q) begin
			r_fold = r_wrap + PI_Q;
			neg    = 1'b1;
		end else begin
			r_fold = r_wrap;
			neg    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1.x <= neg ? -INV_GAIN_Q : INV_GAIN_Q;
			vec_s1.y <= '0;
			vec_s1.z <= r_fold[DW-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

FILE: hw/rtl/cordic_sc_cell.sv
// ----------------------------------------------------------------------------
// cordic rotation cell
// one rotation-mode micro-rotation, registered, wrapping at 16 bits
// ----------------------------------------------------------------------------
module cordic_sc_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [cordic_sc_pkg::SHW-1:0]      stage,
	input  logic                               in_valid,
	input  cordic_sc_pkg::vec_t                in_vec,
	output logic                               out_valid,
	output cordic_sc_pkg::vec_t                out_vec
);
	import cordic_sc_pkg::*;

	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] ys;
	logic signed [DW-1:0] a;
	vec_t                 nxt;
	vec_t                 vec_q;
	logic                 valid_q;

	always_comb begin
		xs = in_vec.x >>> stage;
		ys = in_vec.y >>> stage;
		a  = atan_lut(stage);
		// zero residual counts as non-negative
		if (!in_vec.z[DW-1]) begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - a;
		end else begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule

FILE: hw/rtl/cordic_sine_cosine.sv
// ----------------------------------------------------------------------------
// cordic sine/cosine
// pipelined rotation-mode cordic: one angle in, one sine/cosine pair out
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   width
// s_axis    in   [17:0] angle (q.14, signed)             24
// m_axis    out  [15:0] sine, [31:16] cosine (q.14)      32
//
// one beat accepted per cycle while no result is stalled; the chain is the prep stage plus
// 16 rotation cells, the last cell is the output register
// the whole chain advances together; it stalls only while a result waits
// on m_tready, and bubbles carry a cleared valid bit
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module cordic_sine_cosine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [17:0] angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] sine, [31:16] cosine
);
	import cordic_sc_pkg::*;

	logic                 en;
	logic [STAGES:0]      valid_c;
	vec_t                 vec_c [STAGES+1];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	cordic_sc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.angle     (signed'(s_tdata[AW-1:0])),
		.out_valid (valid_c[0]),
		.out_vec   (vec_c[0])
	);

	for (genvar k = 0; k < STAGES; k++) begin : g_cell
		cordic_sc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.stage     (SHW'(k)),
			.in_valid  (valid_c[k]),
			.in_vec    (vec_c[k]),
			.out_valid (valid_c[k+1]),
			.out_vec   (vec_c[k+1])
		);
	end

	assign m_tvalid = valid_c[STAGES];
	assign m_tdata  = {vec_c[STAGES].x, vec_c[STAGES].y};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	a_accept_enters_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_c[0])
		else $error("accepted beat lost at prep stage");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tvalid && !m_tready) |-> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_chain_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (valid_c[STAGES] == $past(valid_c[STAGES-1])))
		else $error("valid chain broken");

endmodule

FILE: sim/sincos_checker.sv
// ----------------------------------------------------------------------------
// sine/cosine result checker
// watches both stream channels, predicts each result from the accepted angle
// and compares the sine and cosine fields of every result beat in order
// ----------------------------------------------------------------------------
module sincos_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [17:0] angle
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] sine, [31:16] cosine
	output int          pending,
	output int          fails
);

	typedef struct packed {
		logic signed [15:0] cosine;
		logic signed [15:0] sine;
	} trig_t;

	localparam int PI_Q      = 51471;
	localparam int TWO_PI_Q  = 102943;
	localparam int HALF_PI_Q = 25735;
	localparam logic signed [15:0] INV_GAIN = 16'sd9949;
	localparam int REPORT_MAX = 10;

	// arctangent of 2^-k, entry k in bits [16k +: 16]
	localparam logic [255:0] ATAN_TAB = {
		16'h0000, 16'h0000, 16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F,
		16'h007F, 16'h00FF, 16'h01FF, 16'h03FE, 16'h07F5, 16'h0FAD, 16'h1DAC, 16'h3243
	};

	trig_t expected_trig [$];
	int    reported;

	function automatic trig_t cordic_rotate(input logic signed [17:0] ang);
		int                 r;
		logic signed [15:0] x, y, z, xs, ys, nx, a;
		trig_t              res;
		r = ang;
		if (r > PI_Q) begin
			r -= TWO_PI_Q;
		end else if (r < -PI_Q) begin
			r += TWO_PI_Q;
		end
		x = INV_GAIN;
		y = '0;
		// fold into the right half plane and start from the negated vector
		if (r > HALF_PI_Q) begin
			r -= PI_Q;
			x = -x;
		end else if (r < -HALF_PI_Q) begin
			r += PI_Q;
			x = -x;
		end
		z = r[15:0];
		for (int k = 0; k < cordic_sc_pkg::STAGES; k++) begin
			xs = x >>> (k % 16);
			ys = y >>> (k % 16);
			a  = ATAN_TAB[(k % 16)*16 +: 16];
			if (z >= 0) begin
				nx = x - ys;
				y  = y + xs;
				z  = z - a;
			end else begin
				nx = x + ys;
				y  = y - xs;
				z  = z + a;
			end
			x = nx;
		end
		res.sine   = y;
		res.cosine = x;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trig_t want, got;
		if (!arst_n) begin
			expected_trig.delete();
			pending  <= 0;
			fails    <= 0;
			reported <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_trig.push_back(cordic_rotate(s_tdata[17:0]));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_trig.size() == 0) begin
					fails <= fails + 1;
					if (reported < REPORT_MAX)
						$display("%0t: result beat with nothing expected: sine %0d cosine %0d",
							$realtime, got.sine, got.cosine);
					reported <= reported + 1;
				end else begin
					want = expected_trig.pop_front();
					if (got.sine !== want.sine || got.cosine !== want.cosine) begin
						fails <= fails + 1;
						if (reported < REPORT_MAX)
							$display("%0t: mismatch: sine %0d (exp %0d) cosine %0d (exp %0d)",
								$realtime, got.sine, want.sine, got.cosine, want.cosine);
						reported <= reported + 1;
					end
				end
			end
			pending <= expected_trig.size();
		end
	end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// cordic sine/cosine testbench
// drives directed and random angles with random gaps and output stalls;
// the checker predicts every sine/cosine pair and reports the failures
// ----------------------------------------------------------------------------
module tb;

	localparam int N_RANDOM    = 1700;
	localparam int WATCH_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        calm = 1'b0;
	int          pending;
	int          fails;
	int          quiet_cycles = 0;
	int          sent = 0;

	always #5 clk = ~clk;

	cordic_sine_cosine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sincos_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.pending  (pending),
		.fails    (fails)
	);

	// output stalls, none during the calm stretch
	always @(posedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("cordic_sine_cosine regression: fail");
			$finish;
		end
	end

	task automatic send_angle(input int ang);
		while (!calm && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, 18'(ang)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		calm <= (sent >= 700 && sent < 1000);
	endtask

	function automatic int random_angle();
		int edges [10] = '{51471, -51471, 25735, -25735, 102943, -102943,
			77207, -77207, 131071, -131072};
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return $signed(18'($urandom));
		else if (pick < 85)
			return int'($urandom_range(102942)) - 51471;
		else
			return edges[$urandom_range(9)] + int'($urandom_range(8)) - 4;
	endfunction

	initial begin
		int directed [21] = '{0, 1, -1, 131071, -131072, 51471, -51471, 51472, -51472,
			51470, 25735, -25735, 25736, -25736, 102943, -102943, 77207, -77207,
			12868, -12868, 8192};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_angle(directed[i]);
		repeat (N_RANDOM)
			send_angle(random_angle());
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("cordic_sine_cosine regression: pass");
		else
			$display("cordic_sine_cosine regression: fail");
		$finish;
	end

endmodule
